### design/sfvt_pkg.sv
package sfvt_pkg;

  localparam int SensorsDefault = 128;

  localparam logic [7:0] ThresholdReset = 8'd1;
  localparam logic [7:0] PanicCode      = 8'd255;

  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_SWEEP  = 1'b1;

  localparam logic [1:0] CAUSE_NONE      = 2'd0;
  localparam logic [1:0] CAUSE_PANIC     = 2'd1;
  localparam logic [1:0] CAUSE_THRESHOLD = 2'd2;

  typedef struct packed {
    logic       operation;
    logic [6:0] sensor_index;
    logic [7:0] status_code;
    logic       run_error;
  } in_item_t;

  typedef struct packed {
    logic       fire;
    logic [1:0] fire_cause;
    logic [7:0] failed_total;
    logic       latched;
    logic       rearmed;
  } out_item_t;

  // one memory word per sensor
  typedef struct packed {
    logic failed;
    logic last_zero;
  } entry_t;

endpackage

### design/sfvt_ram.sv
module sfvt_ram #(
  parameter int Width = 2,
  parameter int Depth = 128,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/sfvt_update.sv
module sfvt_update #(
  parameter int Sensors = sfvt_pkg::SensorsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               proc_i,
  input  sfvt_pkg::in_item_t item_i,
  input  sfvt_pkg::entry_t   entry_i,
  input  logic [7:0]         thresh_i,
  output logic               we_o,
  output sfvt_pkg::entry_t   wentry_o,
  output sfvt_pkg::out_item_t result_o
);

  localparam int CntW = $clog2(Sensors + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            latch_q, latch_d;
  logic            in_range;
  logic            at_thresh;

  assign in_range  = 32'(item_i.sensor_index) < Sensors;
  assign at_thresh = 32'(count_q) >= 32'(thresh_i);

  always_comb begin
    count_d  = count_q;
    latch_d  = latch_q;
    we_o     = 1'b0;
    wentry_o = entry_i;
    result_o = '0;
    result_o.fire_cause = sfvt_pkg::CAUSE_NONE;
    if (proc_i) begin
      if (item_i.operation == sfvt_pkg::OP_REPORT) begin
        if (!item_i.run_error && in_range) begin
          we_o = 1'b1;
          if (entry_i.last_zero && item_i.status_code != 8'd0) begin
            if (item_i.status_code == sfvt_pkg::PanicCode) begin
              result_o.fire       = 1'b1;
              result_o.fire_cause = sfvt_pkg::CAUSE_PANIC;
            end else if (!entry_i.failed) begin
              wentry_o.failed = 1'b1;
              count_d         = count_q + CntW'(1);
            end
          end else if (entry_i.failed && item_i.status_code == 8'd0) begin
            wentry_o.failed = 1'b0;
            if (count_q != '0) begin
              count_d = count_q - CntW'(1);
            end
          end
          wentry_o.last_zero = (item_i.status_code == 8'd0);
        end
      end else begin
        if (!latch_q && at_thresh) begin
          result_o.fire       = 1'b1;
          result_o.fire_cause = sfvt_pkg::CAUSE_THRESHOLD;
          latch_d             = 1'b1;
        end else if (latch_q && !at_thresh) begin
          latch_d          = 1'b0;
          result_o.rearmed = 1'b1;
        end
      end
    end
    result_o.failed_total = 8'(count_d);
    result_o.latched      = latch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      latch_q <= 1'b0;
    end else begin
      count_q <= count_d;
      latch_q <= latch_d;
    end
  end

  // count is bounded by the sensor count
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= Sensors)
    else $error("failed count above sensor count");

  // count holds in any cycle without a processed transfer
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc_i |=> $stable(count_q))
    else $error("failed count changed without a transfer");

endmodule

### design/sensor_failure_vote_trigger.sv
// Channel  | Handshake                       | Payload
// ---------+---------------------------------+-------------------------
// in       | in_valid_i / in_stall_o         | in_item_i  (in_item_t)
// out      | out_valid_o / out_stall_i       | out_item_o (out_item_t)
// cfg      | cfg_we_i (write only)           | cfg_wdata_i (threshold)
//
// One item per cycle sustained while the output is not stalled; an input
// transfer reaches the result through a read stage on the per-sensor RAM,
// then a modify/write-back stage that loads the output register.
// After reset a clearing pass writes every RAM entry, with
// in_stall_o high throughout; configuration writes are taken meanwhile.
// A stalled output holds the item in the modify stage and stalls the input.
module sensor_failure_vote_trigger #(
  parameter int SENSORS = sfvt_pkg::SensorsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sfvt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sfvt_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);

  localparam int AddrW = (SENSORS > 1) ? $clog2(SENSORS) : 1;

  // configuration
  logic [7:0] thresh_q;

  // clearing pass
  logic             clr_q;
  logic [AddrW-1:0] clr_addr_q;

  // modify stage
  logic               s1_valid_q;
  sfvt_pkg::in_item_t s1_item_q;
  logic               s1_adv;
  logic               proc;

  // write-to-read forwarding: a write at the edge that issued the read
  logic             fwd_hit_q;
  sfvt_pkg::entry_t fwd_data_q;

  // output register
  logic                out_valid_q;
  sfvt_pkg::out_item_t out_item_q;

  // RAM ports
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  sfvt_pkg::entry_t ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  sfvt_pkg::entry_t ram_rdata;

  logic                upd_we;
  sfvt_pkg::entry_t    upd_wentry;
  sfvt_pkg::entry_t    cur_entry;
  sfvt_pkg::out_item_t result;
  logic                in_xfer;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign proc       = s1_valid_q && s1_adv;
  assign in_stall_o = clr_q || (s1_valid_q && !s1_adv);
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign ram_raddr = AddrW'(in_item_i.sensor_index);
  assign ram_we    = clr_q || upd_we;
  assign ram_waddr = clr_q ? clr_addr_q : AddrW'(s1_item_q.sensor_index);
  assign ram_wdata = clr_q ? '0 : upd_wentry;

  assign cur_entry = fwd_hit_q ? fwd_data_q : ram_rdata;

  sfvt_ram #(
    .Width ($bits(sfvt_pkg::entry_t)),
    .Depth (SENSORS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_xfer),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sfvt_update #(
    .Sensors (SENSORS)
  ) u_update (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .proc_i   (proc),
    .item_i   (s1_item_q),
    .entry_i  (cur_entry),
    .thresh_i (thresh_q),
    .we_o     (upd_we),
    .wentry_o (upd_wentry),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= sfvt_pkg::ThresholdReset;
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
        if (clr_addr_q == AddrW'(SENSORS - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= ram_we && (ram_waddr == ram_raddr);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (proc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q  <= in_item_i;
      fwd_data_q <= ram_wdata;
    end
    if (proc) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // fire and cause agree on every result
  a_fire_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.fire == (out_item_o.fire_cause != sfvt_pkg::CAUSE_NONE)))
    else $error("fire flag and cause disagree");

  // a re-arm leaves the latch open and never fires
  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.rearmed) |-> (!out_item_o.fire && !out_item_o.latched))
    else $error("re-arm with fire or latch set");

  // no write from the modify stage during the clearing pass
  a_clr_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s1_valid_q)
    else $error("item in flight during clearing pass");

  // held item keeps its RAM data while the output is stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(cur_entry)))
    else $error("modify stage lost its entry under stall");

endmodule
